// ===== src/sfof_pkg.sv =====
// Shared constants and types for the stream first-occurrence filter.
package sfof_pkg;

  // Width of one list element value.
  localparam int unsigned ValueW = 32;

  // Default number of entries in the seen set.
  localparam int unsigned DefaultCapacity = 64;

  // Result transfer payload width: keep and set_overflow, padded to a byte.
  localparam int unsigned OutDataW = 8;

  // Outcome of looking up one value in the seen set.
  typedef struct packed {
    logic hit;   // value is already recorded in the current list
    logic full;  // no free entry is left to record a new value
  } lookup_t;

endpackage

// ===== src/sfof_seen_set.sv =====
// Set of values already seen in the current list. Every stored entry has its
// own comparator, so a lookup is combinational. Entries fill from index
// zero upwards, so the fill count alone tells which entries are live.
module sfof_seen_set
  import sfof_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ValueW-1:0] value_i,   // value looked up, recorded on commit
  input  logic              commit_i,  // the looked-up item is handed on
  input  logic              last_i,    // item closes its list: empty the set
  output lookup_t           lookup_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [ValueW-1:0] entries_q [Capacity];
  logic [CntW-1:0]   count_q, count_d;
  logic [Capacity-1:0] match;
  logic              record;

  // Compare the value against every live entry in parallel.
  always_comb begin
    for (int unsigned i = 0; i < Capacity; i++) begin
      match[i] = (CntW'(i) < count_q) && (entries_q[i] == value_i);
    end
  end

  assign lookup_o.hit  = |match;
  assign lookup_o.full = (count_q == CntW'(Capacity));

  // A new value is recorded only while a free entry remains.
  assign record = commit_i && !lookup_o.hit && !lookup_o.full;

  // Fill count: emptied after the last element of a list.
  always_comb begin
    count_d = count_q;
    if (commit_i) begin
      if (last_i) begin
        count_d = '0;
      end else if (record) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Entry storage: written at the next free index, read by the comparators.
  always_ff @(posedge clk_i) begin
    if (record) begin
      entries_q[count_q[IdxW-1:0]] <= value_i;
    end
  end

endmodule

// ===== src/stream_first_occurrence_filter_unit.sv =====
// Stream first-occurrence filter. Each input transfer carries one signed
// 32-bit list element in tdata, with tlast marking the last element of its
// list; each produces exactly one result transfer, whose tdata bit 0 (keep) is
// 1 for the first occurrence of a value in the list and 0 for a repeat, bit 1
// (set_overflow) is 1 when a new value could not be recorded because all
// Capacity entries are in use (the value is then kept), and whose tlast copies
// the input tlast. The set is emptied after the element marked tlast. Items
// pass through an input register and then a result register; one item is
// taken every cycle while the result stream accepts them. The rate is set by
// the parallel compare of the held value against all stored entries and the
// update of the set in the same cycle.
module stream_first_occurrence_filter_unit
  import sfof_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ValueW-1:0]   s_axis_tdata_i,   // [31:0] value
  input  logic                s_axis_tlast_i,   // last_of_list
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [0] keep, [1] set_overflow, rest zero
  output logic                m_axis_tlast_o    // end_of_list
);

  logic              in_valid_q, in_valid_d;
  logic [ValueW-1:0] in_value_q;
  logic              in_last_q;
  logic              out_valid_q, out_valid_d;
  logic              out_keep_q;
  logic              out_ovf_q;
  logic              out_last_q;
  logic              in_xfer;
  logic              advance;
  lookup_t           lookup;

  // The held item moves on when the result register is free or being emptied.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  sfof_seen_set #(
    .Capacity (Capacity)
  ) u_seen_set (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (in_value_q),
    .commit_i (advance),
    .last_i   (in_last_q),
    .lookup_o (lookup)
  );

  // Valid flags of the input and result registers.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_value_q <= s_axis_tdata_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  // Result register payload: keep unless repeated, overflow when new but full.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_keep_q <= !lookup.hit;
      out_ovf_q  <= !lookup.hit && lookup.full;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - 2){1'b0}}, out_ovf_q, out_keep_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== sim/stream_first_occurrence_filter_unit_tb.sv =====
module stream_first_occurrence_filter_unit_tb;
  import sfof_pkg::*;

  localparam int unsigned Cap       = DefaultCapacity;
  localparam int unsigned ItemCount = 850;
  localparam int unsigned StallMax  = 2000;
  localparam int unsigned HoldCycles = 200;

  // Shapes of the lists offered in the random part.
  typedef enum logic [1:0] {
    LIST_SHORT_POOL,
    LIST_WIDE,
    LIST_MEDIUM,
    LIST_OVERFLOW
  } list_kind_e;

  // Expected content of one result transfer.
  typedef struct packed {
    logic keep;
    logic set_overflow;
    logic end_of_list;
  } verdict_t;

  // Tracks the seen set of the current list and the verdicts still due.
  class dedup_scoreboard;
    logic [ValueW-1:0] recorded[$];
    verdict_t          due[$];
    int unsigned       capacity;
    int unsigned       errors;
    int unsigned       checked;

    function new(int unsigned cap);
      capacity = cap;
      errors   = 0;
      checked  = 0;
    endfunction

    // Judges one accepted element and queues the verdict it must produce.
    function void note_element(logic [ValueW-1:0] value, logic last);
      verdict_t v;
      logic     hit;
      hit = 1'b0;
      foreach (recorded[i]) begin
        if (recorded[i] == value) hit = 1'b1;
      end
      v.keep         = !hit;
      v.set_overflow = 1'b0;
      v.end_of_list  = last;
      if (!hit) begin
        if (recorded.size() < capacity) recorded.push_back(value);
        else v.set_overflow = 1'b1;
      end
      due.push_back(v);
      // The set is emptied once the last element of a list has been judged.
      if (last) recorded.delete();
    endfunction

    // Compares one result transfer with the oldest verdict due.
    function void check_result(logic [OutDataW-1:0] data, logic last);
      verdict_t    v;
      logic [OutDataW-1:0] want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result transfer, data %h last %b", $time, data, last);
        errors++;
        return;
      end
      v = due.pop_front();
      want = {{(OutDataW-2){1'b0}}, v.set_overflow, v.keep};
      if (data !== want || last !== v.end_of_list) begin
        $display("%0t: result %0d expected data %h last %b, got data %h last %b",
                 $time, checked, want, v.end_of_list, data, last);
        errors++;
      end
      checked++;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic [ValueW-1:0]   s_data = '0;
  logic                s_last = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_last;

  dedup_scoreboard sb;
  int unsigned     items_sent = 0;
  bit              calm = 1'b0;

  stream_first_occurrence_filter_unit #(
    .Capacity(Cap)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offers one element and waits for its transfer, sometimes idling first.
  task automatic send_item(logic [ValueW-1:0] value, logic last);
    if (!calm && $urandom_range(99, 0) < 30) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_last  <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_element(value, last);
    items_sent++;
    // A stretch in the middle of the run with no idling on either side.
    calm = (items_sent >= 450 && items_sent < 600);
  endtask

  // Sends one whole list of the given shape.
  task automatic send_list(list_kind_e kind);
    logic [ValueW-1:0] pool[$];
    logic [ValueW-1:0] base;
    int unsigned       len;
    int unsigned       distinct;
    int unsigned       repeats;
    case (kind)
      LIST_SHORT_POOL: begin
        len = $urandom_range(12, 1);
        repeat ($urandom_range(8, 1)) pool.push_back($urandom);
      end
      LIST_WIDE: begin
        len = $urandom_range(20, 1);
      end
      LIST_MEDIUM: begin
        len = $urandom_range(50, 20);
        repeat ($urandom_range(40, 16)) pool.push_back($urandom);
      end
      default: begin
        // Fill the set past its capacity, then repeat recorded and unrecorded values.
        distinct = Cap + $urandom_range(8, 1);
        repeats  = $urandom_range(10, 2);
        base     = $urandom;
        for (int unsigned i = 0; i < distinct; i++) send_item(base + i, 1'b0);
        for (int unsigned i = 0; i < repeats; i++) begin
          send_item(base + $urandom_range(distinct - 1, 0), i == repeats - 1);
        end
        len = 0;
      end
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pool.size() != 0 ? pool[$urandom_range(pool.size() - 1, 0)] : $urandom,
                i == len - 1);
    end
  endtask

  // Result side: checks each transfer and stalls at random, with one long hold-off.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) sb.check_result(m_data, m_last);
      if (!held && items_sent >= 250) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_ready <= calm || ($urandom_range(99, 0) >= 30);
    end
  end

  // Ends the run when no transfer has happened for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallMax) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sb = new(Cap);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element lists at the extremes of the value range.
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1);
    // Repeats of extreme values within one list.
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    // The set is empty again after the previous list, and a repeat on the last element.
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_0000, 1'b1);
    // Values that differ only in the sign bit are distinct.
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h8000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h8000_0005, 1'b1);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);

    // Random lists; the first one always runs the set into overflow.
    send_list(LIST_OVERFLOW);
    while (items_sent < ItemCount) begin
      case ($urandom_range(99, 0)) inside
        [0:59]:  send_list(LIST_SHORT_POOL);
        [60:74]: send_list(LIST_WIDE);
        [75:89]: send_list(LIST_MEDIUM);
        default: send_list(LIST_OVERFLOW);
      endcase
    end
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
